// ===== rtl/drmv_pkg.sv =====
package drmv_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int TS_W       = 64;
    localparam int CNT_W      = 32;
    localparam int DUR_W      = 32;
    localparam int DEV_W      = 64;
    localparam int OUT_MEAN_W = 48;
    localparam int STATUS_W   = 2;
    localparam int HALF_W     = 32;
    localparam int MEAN_W     = DUR_W + FRAC_BITS;
    localparam int PROD_W     = 2 * MEAN_W;
    localparam int DIV_CNT_W  = $clog2(MEAN_W);
    localparam int MUL_STEPS  = 4;
    localparam int SEL_W      = 2;

    typedef enum logic [STATUS_W-1:0] {
        ST_UPDATED = 2'd0,
        ST_START   = 2'd1,
        ST_REJECT  = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_ABS,
        S_DIV,
        S_FIX,
        S_MUL,
        S_MACC,
        S_UPD,
        S_DONE
    } t_state;

    typedef struct packed {
        logic             load;
        logic             prep;
        logic             absd;
        logic             div_step;
        logic             fix;
        logic             mul_en;
        logic [SEL_W-1:0] mul_sel;
        logic             acc_en;
        logic             upd;
        logic             out_load;
    } t_cmd;

    typedef struct packed {
        logic upd_req;
    } t_sts;

endpackage

// ===== rtl/drmv_in_if.sv =====
interface drmv_in_if import drmv_pkg::*;;
    logic              valid;
    logic              ready;
    logic              mode;
    logic [TS_W-1:0]   timestamp_ns;
    logic [CNT_W-1:0]  sample_count;

    modport source (output valid, output mode, output timestamp_ns, output sample_count,
                    input ready);
    modport sink (input valid, input mode, input timestamp_ns, input sample_count,
                  output ready);
endinterface

// ===== rtl/drmv_out_if.sv =====
interface drmv_out_if import drmv_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [STATUS_W-1:0]   status;
    logic [OUT_MEAN_W-1:0] mean_q16;
    logic [DEV_W-1:0]      sq_dev_sum;

    modport source (output valid, output status, output mean_q16, output sq_dev_sum,
                    input ready);
    modport sink (input valid, input status, input mean_q16, input sq_dev_sum,
                  output ready);
endinterface

// ===== rtl/drmv_ctrl.sv =====
module drmv_ctrl import drmv_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(MEAN_W - 1);
    localparam logic [DIV_CNT_W-1:0] MUL_LAST = DIV_CNT_W'(MUL_STEPS - 1);

    t_state               r_state, n_state;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_out_vld, n_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_out_vld <= n_out_vld;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                n_cnt       = '0;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.upd_req ? S_PREP : S_DONE;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_ABS;
            end
            S_ABS: begin
                o_cmd.absd = 1'b1;
                n_state    = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_cnt   = '0;
                    n_state = S_FIX;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_FIX: begin
                o_cmd.fix = 1'b1;
                n_state   = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = r_cnt[SEL_W-1:0];
                o_cmd.acc_en  = (r_cnt != '0);
                if (r_cnt == MUL_LAST) begin
                    n_cnt   = '0;
                    n_state = S_MACC;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_MACC: begin
                o_cmd.acc_en = 1'b1;
                n_state      = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (!r_out_vld || i_rsp_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_vld = 1'b1;
        end else if (i_rsp_ready) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    assign o_rsp_valid = r_out_vld;

endmodule

// ===== rtl/drmv_dp.sv =====
module drmv_dp import drmv_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  logic                  i_mode,
    input  logic [TS_W-1:0]       i_timestamp_ns,
    input  logic [CNT_W-1:0]      i_sample_count,
    output logic [STATUS_W-1:0]   o_status,
    output logic [OUT_MEAN_W-1:0] o_mean_q16,
    output logic [DEV_W-1:0]      o_sq_dev_sum
);

    logic [TS_W-1:0]       r_start;
    logic [MEAN_W-1:0]     r_mean;
    logic [DEV_W-1:0]      r_dev;
    logic [TS_W-1:0]       r_ts;
    logic [CNT_W-1:0]      r_n;
    t_status               r_status;
    logic [MEAN_W-1:0]     r_x;
    logic                  r_neg;
    logic [MEAN_W-1:0]     r_a;
    logic [MEAN_W-1:0]     r_quo;
    logic [CNT_W-1:0]      r_rem;
    logic [MEAN_W-1:0]     r_mn;
    logic [MEAN_W-1:0]     r_b;
    logic [2*HALF_W-1:0]   r_prod;
    logic [SEL_W-1:0]      r_psel;
    logic [PROD_W-1:0]     r_acc;
    t_status               r_out_status;
    logic [OUT_MEAN_W-1:0] r_out_mean;
    logic [DEV_W-1:0]      r_out_dev;

    logic [TS_W-1:0]     diff;
    logic [DUR_W-1:0]    dur;
    logic                x_lt_m;
    logic [MEAN_W-1:0]   abs_dev;
    logic [CNT_W:0]      rem_sh;
    logic                q_bit;
    logic [HALF_W-1:0]   mul_a;
    logic [HALF_W-1:0]   mul_b;
    logic [2*HALF_W-1:0] prod;
    logic [PROD_W-1:0]   prod_sh;
    logic [DEV_W-1:0]    inc;
    logic [DEV_W:0]      dev_sum;
    t_status             req_status;

    always_comb begin
        if (!i_mode) begin
            req_status = ST_START;
        end else if (i_sample_count == '0) begin
            req_status = ST_REJECT;
        end else begin
            req_status = ST_UPDATED;
        end
    end

    assign o_sts.upd_req = (req_status == ST_UPDATED);

    assign diff    = r_ts - r_start;
    assign dur     = (|diff[TS_W-1:DUR_W]) ? '1 : diff[DUR_W-1:0];
    assign x_lt_m  = (r_x < r_mean);
    assign abs_dev = x_lt_m ? (r_mean - r_x) : (r_x - r_mean);

    assign rem_sh = {r_rem, r_quo[MEAN_W-1]};
    assign q_bit  = (rem_sh >= {1'b0, r_n});

    assign mul_a = i_cmd.mul_sel[1] ? HALF_W'(r_a[MEAN_W-1:HALF_W]) : r_a[HALF_W-1:0];
    assign mul_b = i_cmd.mul_sel[0] ? HALF_W'(r_b[MEAN_W-1:HALF_W]) : r_b[HALF_W-1:0];
    assign prod  = mul_a * mul_b;

    always_comb begin
        unique case (r_psel)
            2'b00:   prod_sh = PROD_W'(r_prod);
            2'b01,
            2'b10:   prod_sh = PROD_W'(r_prod) << HALF_W;
            default: prod_sh = PROD_W'(r_prod) << (2 * HALF_W);
        endcase
    end

    assign inc     = r_acc[2*FRAC_BITS +: DEV_W];
    assign dev_sum = {1'b0, r_dev} + {1'b0, inc};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
            r_mean  <= '0;
            r_dev   <= '0;
        end else begin
            if (i_cmd.load && !i_mode) begin
                r_start <= i_timestamp_ns;
            end
            if (i_cmd.upd) begin
                r_mean <= r_mn;
                r_dev  <= dev_sum[DEV_W] ? '1 : dev_sum[DEV_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ts     <= i_timestamp_ns;
            r_n      <= i_sample_count;
            r_status <= req_status;
        end
        if (i_cmd.prep) begin
            r_x <= {dur, {FRAC_BITS{1'b0}}};
        end
        if (i_cmd.absd) begin
            r_neg <= x_lt_m;
            r_a   <= abs_dev;
            r_quo <= abs_dev;
            r_rem <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= q_bit ? CNT_W'(rem_sh - {1'b0, r_n}) : rem_sh[CNT_W-1:0];
            r_quo <= {r_quo[MEAN_W-2:0], q_bit};
        end
        if (i_cmd.fix) begin
            r_mn  <= r_neg ? (r_mean - r_quo) : (r_mean + r_quo);
            r_b   <= r_a - r_quo;
            r_acc <= '0;
        end
        if (i_cmd.mul_en) begin
            r_prod <= prod;
            r_psel <= i_cmd.mul_sel;
        end
        if (i_cmd.acc_en) begin
            r_acc <= r_acc + prod_sh;
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_status;
            r_out_mean   <= OUT_MEAN_W'(r_mean);
            r_out_dev    <= r_dev;
        end
    end

    assign o_status     = r_out_status;
    assign o_mean_q16   = r_out_mean;
    assign o_sq_dev_sum = r_out_dev;

endmodule

// ===== rtl/duration_running_mean_variance_unit.sv =====
// Duration running mean and variance (Welford update) for event profiling.
// Request channel i_req: mode 0 stores timestamp_ns as the start stamp; mode 1
// forms the duration since that stamp (saturated to 32 bits) and folds it into
// the running mean (unsigned Q32.FRAC_BITS) and the saturating sum of squared
// deviations, using sample_count as the 1-based count n. n of zero is rejected.
// Response channel o_rsp: one response per request, with status and the
// mean and deviation sum after the request.
// Start and rejected requests go from acceptance straight to the done state;
// an update first runs the prep, abs, divide, fix, multiply, accumulate and
// update states. A request is taken only while no other one is in work.
// The bit-serial restoring divider (one quotient bit per cycle over MEAN_W
// bits) sets the update time, followed by four 32x32 partial products.
// A new request is taken while the previous response still waits in the
// output register; a finished result then holds until that register frees.
// Reset (synchronous, active low) clears start stamp, mean and deviation sum
// to zero and empties the output register.
module duration_running_mean_variance_unit import drmv_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    drmv_in_if.sink           i_req,
    drmv_out_if.source        o_rsp
);

    t_cmd cmd;
    t_sts sts;

    drmv_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    drmv_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_mode         (i_req.mode),
        .i_timestamp_ns (i_req.timestamp_ns),
        .i_sample_count (i_req.sample_count),
        .o_status       (o_rsp.status),
        .o_mean_q16     (o_rsp.mean_q16),
        .o_sq_dev_sum   (o_rsp.sq_dev_sum)
    );

    a_one_request_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> !i_req.ready)
        else $error("request accepted while previous one still in work");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.status == ST_UPDATED || o_rsp.status == ST_START ||
                         o_rsp.status == ST_REJECT))
        else $error("response carries unknown status");

endmodule
